[design/prtt_pkg.sv]
// Shared constants and codes for the pending request timeout table.
// Depends on nothing; the top level imports it.
package prtt_pkg;

    localparam int SLOT_COUNT_DEF       = 24;
    localparam int REQUEST_TAG_BITS_DEF = 32;
    localparam int SOURCE_TAG_BITS_DEF  = 16;

    localparam int REQ_PORT_W = 32;
    localparam int SRC_PORT_W = 16;
    localparam int TIMEOUT_W  = 32;
    localparam int TIME_W     = 64;
    localparam int EVENTS_W   = 5;

    localparam logic [TIMEOUT_W-1:0] DEFAULT_TIMEOUT_RESET = 32'd5000;

    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_EXPIRED = 1'b1;

    typedef enum logic [1:0] {
        FUNC_TRACK     = 2'd0,
        FUNC_CLEAR     = 2'd1,
        FUNC_POLL      = 2'd2,
        FUNC_RESET_ALL = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_ROOM = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef struct packed {
        logic                  kind;
        status_t               status;
        logic [REQ_PORT_W-1:0] request;
        logic [SRC_PORT_W-1:0] source;
        logic [TIME_W-1:0]     event_time;
        logic [EVENTS_W-1:0]   count;
        logic                  last;
    } result_t;

endpackage

[design/pending_request_timeout_table.sv]
// Pending request timeout table: slot store, scan sequencer and result register.
// Depends on prtt_pkg for widths, operation codes and status codes.
//
// A request is accepted when start is high and busy is low; busy stays high until the
// final result of that request has been loaded. Slots are visited one per cycle through a
// single shared compare path fed by the slot memory's registered read port. A request with
// a zero tag, a reset-all and a poll with event_limit of zero finish at once.
// Results come on the cycle after they are decided, one per cycle, each marked by
// result_valid for exactly one cycle; the receiver cannot stall and must take every one.
// Expired entries of a poll come in slot order ahead of its final count result, and every
// request ends with one result that has last set.
module pending_request_timeout_table
    #(
        parameter int SLOT_COUNT       = prtt_pkg::SLOT_COUNT_DEF,
        parameter int REQUEST_TAG_BITS = prtt_pkg::REQUEST_TAG_BITS_DEF,
        parameter int SOURCE_TAG_BITS  = prtt_pkg::SOURCE_TAG_BITS_DEF
    )
    (
        input  logic                            clk,
        input  logic                            rst_n,
        input  logic                            cfg_write,
        input  logic [prtt_pkg::TIMEOUT_W-1:0]  cfg_data,
        input  logic                            start,
        output logic                            busy,
        input  logic [1:0]                      func,
        input  logic [prtt_pkg::REQ_PORT_W-1:0] request_tag,
        input  logic [prtt_pkg::SRC_PORT_W-1:0] source_tag,
        input  logic [prtt_pkg::TIMEOUT_W-1:0]  track_timeout,
        input  logic [prtt_pkg::TIME_W-1:0]     now_ms,
        input  logic [prtt_pkg::EVENTS_W-1:0]   event_limit,
        output logic                            result_valid,
        output logic                            kind,
        output logic [1:0]                      status,
        output logic [prtt_pkg::REQ_PORT_W-1:0] expired_request,
        output logic [prtt_pkg::SRC_PORT_W-1:0] expired_source,
        output logic [prtt_pkg::TIME_W-1:0]     event_time_ms,
        output logic [prtt_pkg::EVENTS_W-1:0]   emitted_count,
        output logic                            last
    );

    import prtt_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINAL
    } state_t;

    function automatic result_t final_result(status_t st, logic [EVENTS_W-1:0] cnt);
        result_t r;
        r            = '0;
        r.kind       = KIND_STATUS;
        r.status     = st;
        r.count      = cnt;
        r.last       = 1'b1;
        return r;
    endfunction

    state_t                       state_reg;
    logic [IDX_W-1:0]             idx_reg;
    func_t                        op_func_reg;
    logic [REQUEST_TAG_BITS-1:0]  op_req_reg;
    logic [SOURCE_TAG_BITS-1:0]   op_src_reg;
    logic [TIME_W-1:0]            op_now_reg;
    logic [TIME_W-1:0]            op_deadline_reg;
    logic [EVENTS_W-1:0]          op_max_reg;
    logic [EVENTS_W-1:0]          count_reg;
    logic                         free_found_reg;
    logic [IDX_W-1:0]             free_idx_reg;
    logic [SLOT_COUNT-1:0]        valid_reg;
    logic [TIMEOUT_W-1:0]         default_timeout_reg;
    result_t                      res_reg;
    logic                         res_valid_reg;

    logic [TIME_W-1:0]            deadline_mem [SLOT_COUNT];
    logic [REQUEST_TAG_BITS-1:0]  request_mem  [SLOT_COUNT];
    logic [SOURCE_TAG_BITS-1:0]   source_mem   [SLOT_COUNT];
    logic [TIME_W-1:0]            rd_deadline_reg;
    logic [REQUEST_TAG_BITS-1:0]  rd_request_reg;
    logic [SOURCE_TAG_BITS-1:0]   rd_source_reg;

    logic                         accept;
    logic [REQUEST_TAG_BITS-1:0]  req_in;
    logic [SOURCE_TAG_BITS-1:0]   src_in;
    logic [TIMEOUT_W-1:0]         timeout_sel;
    logic [IDX_W-1:0]             rd_addr;
    logic                         at_last;
    logic                         slot_live;
    logic                         req_hit;
    logic [TIME_W-1:0]            age;
    logic                         due;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic [EVENTS_W-1:0]          count_inc;
    result_t                      event_res;

    assign accept      = start && (state_reg == ST_IDLE);
    assign busy        = (state_reg != ST_IDLE);
    assign req_in      = REQUEST_TAG_BITS'(request_tag);
    assign src_in      = SOURCE_TAG_BITS'(source_tag);
    assign timeout_sel = (track_timeout == '0) ? default_timeout_reg : track_timeout;

    assign at_last   = (idx_reg == LAST_IDX);
    assign rd_addr   = (state_reg == ST_IDLE) ? '0 : (at_last ? idx_reg : idx_reg + 1'b1);
    assign slot_live = valid_reg[idx_reg];
    assign req_hit   = slot_live && (rd_request_reg == op_req_reg);
    assign age       = op_now_reg - rd_deadline_reg;
    assign due       = slot_live && (rd_deadline_reg != '0) && !age[TIME_W-1];
    assign count_inc = count_reg + 1'b1;

    assign wr_en   = (state_reg == ST_SCAN) && (op_func_reg == FUNC_TRACK)
                     && (req_hit || (at_last && (free_found_reg || !slot_live)));
    assign wr_addr = (req_hit || !free_found_reg) ? idx_reg : free_idx_reg;

    always_comb
    begin
        event_res            = '0;
        event_res.kind       = KIND_EXPIRED;
        event_res.status     = STATUS_OK;
        event_res.request    = REQ_PORT_W'(rd_request_reg);
        event_res.source     = SRC_PORT_W'(rd_source_reg);
        event_res.event_time = op_now_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            deadline_mem[wr_addr] <= op_deadline_reg;
            request_mem[wr_addr]  <= op_req_reg;
            source_mem[wr_addr]   <= op_src_reg;
        end
        rd_deadline_reg <= deadline_mem[rd_addr];
        rd_request_reg  <= request_mem[rd_addr];
        rd_source_reg   <= source_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            idx_reg             <= '0;
            op_func_reg         <= FUNC_TRACK;
            op_req_reg          <= '0;
            op_src_reg          <= '0;
            op_now_reg          <= '0;
            op_deadline_reg     <= '0;
            op_max_reg          <= '0;
            count_reg           <= '0;
            free_found_reg      <= 1'b0;
            free_idx_reg        <= '0;
            valid_reg           <= '0;
            default_timeout_reg <= DEFAULT_TIMEOUT_RESET;
            res_reg             <= '0;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            if (cfg_write)
            begin
                default_timeout_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_func_reg     <= func_t'(func);
                        op_req_reg      <= req_in;
                        op_src_reg      <= src_in;
                        op_now_reg      <= now_ms;
                        op_deadline_reg <= now_ms + TIME_W'(timeout_sel);
                        op_max_reg      <= event_limit;
                        idx_reg         <= '0;
                        count_reg       <= '0;
                        free_found_reg  <= 1'b0;
                        unique case (func_t'(func))
                            FUNC_TRACK:
                            begin
                                if (req_in == '0 || src_in == '0)
                                begin
                                    res_reg       <= final_result(STATUS_INVALID, '0);
                                    res_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            FUNC_CLEAR:
                            begin
                                if (req_in == '0)
                                begin
                                    res_reg       <= final_result(STATUS_INVALID, '0);
                                    res_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            FUNC_POLL:
                            begin
                                if (event_limit == '0)
                                begin
                                    res_reg       <= final_result(STATUS_OK, '0);
                                    res_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            FUNC_RESET_ALL:
                            begin
                                valid_reg     <= '0;
                                res_reg       <= final_result(STATUS_OK, '0);
                                res_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    unique case (op_func_reg)
                        FUNC_TRACK:
                        begin
                            if (wr_en)
                            begin
                                valid_reg[wr_addr] <= 1'b1;
                                res_reg            <= final_result(STATUS_OK, '0);
                                res_valid_reg      <= 1'b1;
                                state_reg          <= ST_IDLE;
                            end
                            else if (at_last)
                            begin
                                res_reg       <= final_result(STATUS_NO_ROOM, '0);
                                res_valid_reg <= 1'b1;
                                state_reg     <= ST_IDLE;
                            end
                            else
                            begin
                                if (!slot_live && !free_found_reg)
                                begin
                                    free_found_reg <= 1'b1;
                                    free_idx_reg   <= idx_reg;
                                end
                                idx_reg <= idx_reg + 1'b1;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            if (req_hit || at_last)
                            begin
                                if (req_hit)
                                begin
                                    valid_reg[idx_reg] <= 1'b0;
                                end
                                res_reg       <= final_result(STATUS_OK, '0);
                                res_valid_reg <= 1'b1;
                                state_reg     <= ST_IDLE;
                            end
                            else
                            begin
                                idx_reg <= idx_reg + 1'b1;
                            end
                        end
                        FUNC_POLL:
                        begin
                            if (due)
                            begin
                                valid_reg[idx_reg] <= 1'b0;
                                res_reg            <= event_res;
                                res_valid_reg      <= 1'b1;
                                count_reg          <= count_inc;
                                if (count_inc == op_max_reg || at_last)
                                begin
                                    state_reg <= ST_FINAL;
                                end
                                else
                                begin
                                    idx_reg <= idx_reg + 1'b1;
                                end
                            end
                            else if (at_last)
                            begin
                                res_reg       <= final_result(STATUS_OK, count_reg);
                                res_valid_reg <= 1'b1;
                                state_reg     <= ST_IDLE;
                            end
                            else
                            begin
                                idx_reg <= idx_reg + 1'b1;
                            end
                        end
                        FUNC_RESET_ALL:
                        begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_FINAL:
                begin
                    res_reg       <= final_result(STATUS_OK, count_reg);
                    res_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid    = res_valid_reg;
    assign kind            = res_reg.kind;
    assign status          = res_reg.status;
    assign expired_request = res_reg.request;
    assign expired_source  = res_reg.source;
    assign event_time_ms   = res_reg.event_time;
    assign emitted_count   = res_reg.count;
    assign last            = res_reg.last;

endmodule
